// File: design/grid_rect_fill_scan_unit_macros.svh
// Assertion macros shared by the checker of the grid rectangle fill and scan unit.
// Holds only macro definitions; no dependencies.
`ifndef GRID_RECT_FILL_SCAN_UNIT_MACROS_SVH
`define GRID_RECT_FILL_SCAN_UNIT_MACROS_SVH

// Clocked property that is switched off while reset is high.
`define GRFS_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked across reset.
`define GRFS_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/grfs_pkg.sv
// Package for the grid rectangle fill and scan unit: widths, codes, state and
// command types shared by the controller, datapath, top level and checker.
`timescale 1ns / 1ps

package grfs_pkg;

  localparam int COORD_BITS  = 3;
  localparam int DIM_BITS    = 4;
  localparam int EXT_BITS    = 7;
  localparam int CLIP_BITS   = 9;
  localparam int ENTITY_W    = 16;
  localparam int KIND_BITS   = 2;
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 24;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  localparam logic ACT_FILL = 1'b0;
  localparam logic ACT_SCAN = 1'b1;

  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_DONE  = 2'd0,
    KIND_FOUND = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_DISPATCH,
    ST_FILL,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE,
    ST_ERR
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_FOUND,
    EMIT_DONE,
    EMIT_ERROR
  } emit_t;

  typedef struct packed {
    logic                  err;
    logic [COORD_BITS-1:0] lo;
    logic [COORD_BITS-1:0] hi;
  } axis_t;

  typedef struct packed {
    logic  load_in;
    logic  clip_load;
    logic  cur_step;
    logic  mem_we;
    logic  mem_re;
    emit_t emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clip_err;
    logic is_scan;
    logic rect_empty;
    logic walk_last;
    logic cell_hit;
    logic out_free;
  } dp_stat_t;

endpackage

// File: design/grfs_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps

module grfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/grfs_ctrl.sv
// Controller state machine of the grid rectangle fill and scan unit.
// Depends on grfs_pkg for the state, command and status types.
`timescale 1ns / 1ps

module grfs_ctrl
  import grfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CLIP;
        end
      end
      ST_CLIP: begin
        state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (stat.clip_err) begin
          state_next = ST_ERR;
        end else if (!stat.is_scan) begin
          state_next = ST_FILL;
        end else if (stat.rect_empty) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_FILL: begin
        if (stat.walk_last) begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (!stat.cell_hit || stat.out_free) begin
          state_next = stat.walk_last ? ST_DONE : ST_SCAN_RD;
        end
      end
      ST_DONE, ST_ERR: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_CLIP: begin
        cmd.clip_load = 1'b1;
      end
      ST_FILL: begin
        cmd.mem_we   = 1'b1;
        cmd.cur_step = 1'b1;
      end
      ST_SCAN_RD: begin
        cmd.mem_re = 1'b1;
      end
      ST_SCAN_CHK: begin
        if (!stat.cell_hit || stat.out_free) begin
          cmd.cur_step = !stat.walk_last;
          if (stat.cell_hit) begin
            cmd.emit = EMIT_FOUND;
          end
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.emit = EMIT_DONE;
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          cmd.emit = EMIT_ERROR;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: design/grfs_dp.sv
// Datapath of the grid rectangle fill and scan unit: request registers, clipper,
// cell cursor, grid memory with per-cell valid bits, and the result register.
// Depends on grfs_pkg and grfs_ram.
`timescale 1ns / 1ps

module grfs_dp
  import grfs_pkg::*;
#(
  parameter int MAX_WIDTH   = 8,
  parameter int MAX_HEIGHT  = 8,
  parameter int ENTITY_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic                    in_action,
  input  logic [EXT_BITS-1:0]     in_left_x,
  input  logic [EXT_BITS-1:0]     in_top_y,
  input  logic [EXT_BITS-1:0]     in_width_extent,
  input  logic [EXT_BITS-1:0]     in_height_extent,
  input  logic [ENTITY_W-1:0]     in_entity_id,
  input  logic [DIM_BITS-1:0]     map_width,
  input  logic [DIM_BITS-1:0]     map_height,
  input  logic                    out_ready,
  output logic                    out_valid,
  output kind_t                   out_kind,
  output logic [COORD_BITS-1:0]   out_cell_x,
  output logic [COORD_BITS-1:0]   out_cell_y,
  output logic [ENTITY_W-1:0]     out_found_entity,
  output logic                    out_last
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [DIM_BITS-1:0] MW_MAX = DIM_BITS'(MAX_WIDTH);
  localparam logic [DIM_BITS-1:0] MH_MAX = DIM_BITS'(MAX_HEIGHT);
  localparam logic [DIM_BITS-1:0] DIM_ONE = DIM_BITS'(1);

  // Clip one axis: pull a negative start to zero, then limit the inclusive end
  // to the last column or row in use.
  function automatic axis_t clip_axis(input logic [EXT_BITS-1:0] pos,
                                      input logic [EXT_BITS-1:0] ext,
                                      input logic [DIM_BITS-1:0] dim);
    logic signed [CLIP_BITS-1:0] p;
    logic signed [CLIP_BITS-1:0] e;
    logic signed [CLIP_BITS-1:0] b;
    logic signed [CLIP_BITS-1:0] d;
    axis_t r;
    p = {{(CLIP_BITS-EXT_BITS){pos[EXT_BITS-1]}}, pos};
    e = {{(CLIP_BITS-EXT_BITS){ext[EXT_BITS-1]}}, ext};
    d = {{(CLIP_BITS-DIM_BITS){1'b0}}, dim};
    if (p < 0) begin
      e = e + p;
      p = '0;
    end
    b = p + e;
    if (b >= d) begin
      e = d - CLIP_BITS'(1) - p;
      b = d - CLIP_BITS'(1);
    end
    r.err = (p > d) || (e < 0);
    r.lo  = p[COORD_BITS-1:0];
    r.hi  = b[COORD_BITS-1:0];
    return r;
  endfunction

  // Request registers.
  logic                   act_q;
  logic [EXT_BITS-1:0]    lx_q;
  logic [EXT_BITS-1:0]    ty_q;
  logic [EXT_BITS-1:0]    w_q;
  logic [EXT_BITS-1:0]    h_q;
  logic [ENTITY_BITS-1:0] ent_q;
  logic [31:0]            ent_ext;

  assign ent_ext = 32'(in_entity_id);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_q <= in_action;
      lx_q  <= in_left_x;
      ty_q  <= in_top_y;
      w_q   <= in_width_extent;
      h_q   <= in_height_extent;
      ent_q <= ent_ext[ENTITY_BITS-1:0];
    end
  end

  // Map size in use, with zero read as one and anything above the grid as the grid.
  logic [DIM_BITS-1:0] mw_eff;
  logic [DIM_BITS-1:0] mh_eff;

  assign mw_eff = (map_width == '0) ? DIM_ONE : ((map_width > MW_MAX) ? MW_MAX : map_width);
  assign mh_eff = (map_height == '0) ? DIM_ONE :
                  ((map_height > MH_MAX) ? MH_MAX : map_height);

  axis_t ax_x;
  axis_t ax_y;

  assign ax_x = clip_axis(lx_q, w_q, mw_eff);
  assign ax_y = clip_axis(ty_q, h_q, mh_eff);

  // Clipped rectangle and walking cursor.
  logic                  err_q;
  logic [COORD_BITS-1:0] x0;
  logic [COORD_BITS-1:0] x1;
  logic [COORD_BITS-1:0] y0;
  logic [COORD_BITS-1:0] y1;
  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  // A scan stops one short of the inclusive corner on both axes.
  assign x_end = (act_q == ACT_SCAN) ? x1 - COORD_BITS'(1) : x1;
  assign y_end = (act_q == ACT_SCAN) ? y1 - COORD_BITS'(1) : y1;

  always_ff @(posedge clk) begin
    if (cmd.clip_load) begin
      err_q <= ax_x.err || ax_y.err;
      x0    <= ax_x.lo;
      x1    <= ax_x.hi;
      y0    <= ax_y.lo;
      y1    <= ax_y.hi;
      cx    <= ax_x.lo;
      cy    <= ax_y.lo;
    end else if (cmd.cur_step) begin
      if (cx == x_end) begin
        cx <= x0;
        cy <= cy + COORD_BITS'(1);
      end else begin
        cx <= cx + COORD_BITS'(1);
      end
    end
  end

  // Grid memory; cells never written since reset read as empty.
  logic [31:0]            addr_full;
  logic [AW-1:0]          addr;
  logic [DEPTH-1:0]       cell_valid;
  logic                   rd_valid;
  logic [ENTITY_BITS-1:0] ram_rdata;
  logic [ENTITY_BITS-1:0] cell_value;
  logic [31:0]            value_ext;

  assign addr_full = 32'(cy) * 32'(MAX_WIDTH) + 32'(cx);
  assign addr      = addr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= '0;
    end else if (cmd.mem_we) begin
      cell_valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_re) begin
      rd_valid <= cell_valid[addr];
    end
  end

  grfs_ram #(
    .WIDTH(ENTITY_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.mem_we),
    .waddr(addr),
    .wdata(ent_q),
    .re   (cmd.mem_re),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  assign cell_value = rd_valid ? ram_rdata : '0;
  assign value_ext  = 32'(cell_value);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_FOUND: begin
        out_kind         <= KIND_FOUND;
        out_cell_x       <= cx;
        out_cell_y       <= cy;
        out_found_entity <= value_ext[ENTITY_W-1:0];
        out_last         <= 1'b0;
      end
      EMIT_DONE: begin
        out_kind         <= KIND_DONE;
        out_cell_x       <= '0;
        out_cell_y       <= '0;
        out_found_entity <= '0;
        out_last         <= 1'b1;
      end
      EMIT_ERROR: begin
        out_kind         <= KIND_ERROR;
        out_cell_x       <= '0;
        out_cell_y       <= '0;
        out_found_entity <= '0;
        out_last         <= 1'b1;
      end
      default: begin
        out_kind <= out_kind;
      end
    endcase
  end

  always_comb begin
    stat.clip_err   = err_q;
    stat.is_scan    = (act_q == ACT_SCAN);
    stat.rect_empty = (x0 == x1) || (y0 == y1);
    stat.walk_last  = (cx == x_end) && (cy == y_end);
    stat.cell_hit   = (cell_value != '0);
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

// File: design/grid_rect_fill_scan_unit.sv
// Top level of the grid rectangle fill and scan unit: stream ports, APB
// register file, controller and datapath. Depends on grfs_pkg, grfs_ctrl, grfs_dp.
//
//   Channel    Direction  Transaction content
//   s_axis     in         one request: tuser = action, tdata = corner, size, entity
//   m_axis     out        one result: tuser = kind, tdata = cell and entity, tlast
//   apb        in/out     map_width at 0x0, map_height at 0x4
//
// A fill writes one cell per cycle over the clipped inclusive rectangle, then
// gives its done result. A scan reads memory for every visited cell and then
// looks at the registered read data in a state of its own before moving on.
// Reset clears every cell at once through per-cell valid bits; no clearing pass.
// A stalled m_axis holds the scan on an occupied cell; a request is taken only
// while the block is between requests, even if the final result still waits.
`timescale 1ns / 1ps

module grid_rect_fill_scan_unit
  import grfs_pkg::*;
#(
  parameter int MAX_WIDTH   = 8,
  parameter int MAX_HEIGHT  = 8,
  parameter int ENTITY_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // Request stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: left_x[6:0], top_y[13:7], width_extent[20:14], height_extent[27:21],
  // entity_id[43:28], zero fill[47:44]
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: action[0]
  input  logic [0:0]            s_axis_tuser,
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: cell_x[2:0], cell_y[5:3], found_entity[21:6], zero fill[23:22]
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // tuser: kind[1:0]
  output logic [KIND_BITS-1:0]  m_axis_tuser,
  output logic                  m_axis_tlast,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // The register file. Only the register select bit of the address is decoded,
  // and the low four data bits are kept.
  logic [DIM_BITS-1:0] map_width;
  logic [DIM_BITS-1:0] map_height;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= DIM_BITS'(8);
      map_height <= DIM_BITS'(8);
    end else if (cfg_write) begin
      if (paddr[2] == REG_MAP_HEIGHT) begin
        map_height <= pwdata[DIM_BITS-1:0];
      end else begin
        map_width <= pwdata[DIM_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MAP_WIDTH) ? CFG_DATA_W'(map_width)
                                              : CFG_DATA_W'(map_height);

  // Controller and datapath talk only through the command and status structs.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  grfs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  kind_t                 out_kind;
  logic [COORD_BITS-1:0] out_cell_x;
  logic [COORD_BITS-1:0] out_cell_y;
  logic [ENTITY_W-1:0]   out_found_entity;

  grfs_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ENTITY_BITS(ENTITY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (s_axis_tuser[0]),
    .in_left_x       (s_axis_tdata[6:0]),
    .in_top_y        (s_axis_tdata[13:7]),
    .in_width_extent (s_axis_tdata[20:14]),
    .in_height_extent(s_axis_tdata[27:21]),
    .in_entity_id    (s_axis_tdata[43:28]),
    .map_width       (map_width),
    .map_height      (map_height),
    .out_ready       (m_axis_tready),
    .out_valid       (m_axis_tvalid),
    .out_kind        (out_kind),
    .out_cell_x      (out_cell_x),
    .out_cell_y      (out_cell_y),
    .out_found_entity(out_found_entity),
    .out_last        (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {2'b00, out_found_entity, out_cell_y, out_cell_x};

endmodule

// File: design/grfs_checker.sv
// Port-level checker for the grid rectangle fill and scan unit, bound to the top.
// Depends on grfs_pkg and grid_rect_fill_scan_unit_macros.svh.
`timescale 1ns / 1ps
`include "grid_rect_fill_scan_unit_macros.svh"

module grfs_checker
  import grfs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [KIND_BITS-1:0] m_axis_tuser,
  input logic                 m_axis_tlast
);

  // A stalled result keeps its contents.
  `GRFS_ASSERT_CLK(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

  // No result is left over from before reset.
  `GRFS_ASSERT_RST(a_out_reset, clk, rst |=> !m_axis_tvalid, "result valid right after reset")

  // Found cells never close a request; done and error results always do.
  `GRFS_ASSERT_CLK(a_last_kind, clk, rst, m_axis_tvalid |-> ((m_axis_tuser == KIND_FOUND) != m_axis_tlast), "tlast does not match result kind")

  // Closing results carry no cell and no entity.
  `GRFS_ASSERT_CLK(a_close_zero, clk, rst, m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata == '0), "closing result has nonzero data")

  // One request at a time: the request port closes right after a transaction.
  `GRFS_ASSERT_CLK(a_in_busy, clk, rst, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while busy")

endmodule

bind grid_rect_fill_scan_unit grfs_checker u_grfs_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

// File: dv/grid_rect_fill_scan_unit_tb.sv
// Self-checking testbench for grid_rect_fill_scan_unit: directed and random
// fill and scan requests, APB map size changes, checked against a predictor.
// Depends on grfs_pkg and the grid_rect_fill_scan_unit RTL.
`timescale 1ns / 1ps

module grid_rect_fill_scan_unit_tb;
  import grfs_pkg::*;

  localparam int GRID_W         = 8;
  localparam int GRID_H         = 8;
  localparam int STALL_PCT      = 36;
  localparam int PHASE_COUNT    = 8;
  localparam int ITEMS_PER_SIZE = 48;
  // Longest correct silence is a scan over empty cells followed by a long run
  // of receiver stalls; this is several times that.
  localparam int WATCHDOG_LIMIT = 2000;
  // Tail wait after the last result, a little more than the slowest scan.
  localparam int TAIL_CYCLES    = 110;

  // One request as the sender presents it.
  typedef struct {
    logic              action;
    logic signed [6:0] left_x;
    logic signed [6:0] top_y;
    logic signed [6:0] w_ext;
    logic signed [6:0] h_ext;
    logic [15:0]       entity;
  } rect_req_t;

  // One result as the block should return it.
  typedef struct {
    kind_t       kind;
    logic [2:0]  cell_x;
    logic [2:0]  cell_y;
    logic [15:0] entity;
    logic        last;
  } cell_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [KIND_BITS-1:0]  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  grid_rect_fill_scan_unit #(
    .MAX_WIDTH  (GRID_W),
    .MAX_HEIGHT (GRID_H),
    .ENTITY_BITS(16)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the grid and of the two size registers. The registers keep
  // the raw 4-bit value that was written; clamping happens when it is used.
  logic [15:0]  grid_shadow [GRID_W*GRID_H];
  logic [3:0]   width_reg;
  logic [3:0]   height_reg;

  rect_req_t    pending_requests [$];
  cell_result_t expected_results [$];
  rect_req_t    driven_req;
  cell_result_t head_result;

  bit           req_taken = 1'b0;
  bit           no_stall = 1'b0;
  int           mismatch_count = 0;
  int           idle_cycles = 0;
  int           fill_count = 0;
  int           scan_count = 0;
  int           reject_count = 0;
  int           found_count = 0;
  int           size_count = 0;

  function automatic int clamp_size(input logic [3:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void push_result(input kind_t k, input int x, input int y,
                                      input logic [15:0] ent, input logic last);
    cell_result_t r;
    r.kind   = k;
    r.cell_x = 3'(x);
    r.cell_y = 3'(y);
    r.entity = ent;
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  // Clips the rectangle against the current map size, applies a fill to the
  // shadow grid or walks a scan over it, and queues the results it causes.
  function automatic void predict_rect_results(input rect_req_t r);
    int mw, mh, lx, ty, w, h, bx, by, n;
    mw = clamp_size(width_reg, GRID_W);
    mh = clamp_size(height_reg, GRID_H);
    lx = r.left_x;
    ty = r.top_y;
    w  = r.w_ext;
    h  = r.h_ext;
    n  = 0;
    // A negative corner moves to zero and shortens the size by as much.
    if (lx < 0) begin
      w  = w + lx;
      lx = 0;
    end
    if (ty < 0) begin
      h  = h + ty;
      ty = 0;
    end
    // The inclusive bottom-right corner is pulled back to the last column or row.
    bx = lx + w;
    by = ty + h;
    if (bx >= mw) begin
      w  = w - (bx - mw + 1);
      bx = lx + w;
    end
    if (by >= mh) begin
      h  = h - (by - mh + 1);
      by = ty + h;
    end
    if (lx > mw || ty > mh || w < 0 || h < 0 || bx >= mw || by >= mh) begin
      reject_count++;
      push_result(KIND_ERROR, 0, 0, '0, 1'b1);
      return;
    end
    if (r.action == ACT_FILL) begin
      fill_count++;
      for (int y = ty; y <= by; y++)
        for (int x = lx; x <= bx; x++)
          if (x < GRID_W && y < GRID_H) grid_shadow[y*GRID_W + x] = r.entity;
      push_result(KIND_DONE, 0, 0, '0, 1'b1);
      return;
    end
    // A scan covers the exclusive rectangle, so it stops one short of the
    // clipped right column and bottom row.
    scan_count++;
    for (int y = ty; y < ty + h; y++)
      for (int x = lx; x < lx + w; x++)
        if (x < GRID_W && y < GRID_H && n < 63 && grid_shadow[y*GRID_W + x] != 0) begin
          push_result(KIND_FOUND, x, y, grid_shadow[y*GRID_W + x], 1'b0);
          n++;
        end
    push_result(KIND_DONE, 0, 0, '0, 1'b1);
  endfunction

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  function automatic void push_req(input logic act, input int lx, input int ty,
                                   input int w, input int h, input int ent);
    rect_req_t r;
    r.action = act;
    r.left_x = 7'(lx);
    r.top_y  = 7'(ty);
    r.w_ext  = 7'(w);
    r.h_ext  = 7'(h);
    r.entity = 16'(ent);
    pending_requests.push_back(r);
  endfunction

  // Most requests are sized around the current map so that they get past the
  // clipping and do real work; the rest take any value the fields allow.
  function automatic void push_random_req();
    int  mw, mh, ent;
    logic act;
    mw  = clamp_size(width_reg, GRID_W);
    mh  = clamp_size(height_reg, GRID_H);
    act = ($urandom_range(99, 0) < 55) ? ACT_FILL : ACT_SCAN;
    ent = ($urandom_range(99, 0) < 15) ? 0 : int'($urandom_range(16'hFFFF, 1));
    if ($urandom_range(99, 0) < 80)
      push_req(act, int'($urandom_range(mw + 2, 0)) - 2, int'($urandom_range(mh + 2, 0)) - 2,
               int'($urandom_range(mw + 3, 0)) - 1, int'($urandom_range(mh + 3, 0)) - 1, ent);
    else
      push_req(act, int'($urandom), int'($urandom), int'($urandom), int'($urandom),
               int'($urandom));
  endfunction

  // Request driver: unless a random stall holds it back, a new transaction is offered
  // at the falling edge once the previous one was taken, or after an idle cycle.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (pending_requests.size() != 0 &&
          (no_stall || $urandom_range(99, 0) >= STALL_PCT)) begin
        driven_req = pending_requests.pop_front();
        s_axis_tdata  <= {4'b0, driven_req.entity, driven_req.h_ext, driven_req.w_ext,
                          driven_req.top_y, driven_req.left_x};
        s_axis_tuser  <= driven_req.action;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // The result side stalls at random unless a no-stall stretch is running.
  always @(negedge clk) begin
    m_axis_tready <= !rst && (no_stall || $urandom_range(99, 0) >= STALL_PCT);
  end

  // Accepted requests go straight to the predictor at the edge that takes them.
  always @(posedge clk) begin
    req_taken = !rst && s_axis_tvalid && s_axis_tready;
    if (req_taken) predict_rect_results(driven_req);
  end

  // Every accepted result is compared with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tuser == KIND_FOUND) found_count++;
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: kind %0d tdata %h last %b",
                                m_axis_tuser, m_axis_tdata, m_axis_tlast));
      end else begin
        head_result = expected_results.pop_front();
        if (m_axis_tuser !== head_result.kind || m_axis_tdata[2:0] !== head_result.cell_x ||
            m_axis_tdata[5:3] !== head_result.cell_y ||
            m_axis_tdata[21:6] !== head_result.entity || m_axis_tlast !== head_result.last)
          note_mismatch($sformatf(
            "expected kind %0d x %0d y %0d id %h last %b, got kind %0d x %0d y %0d id %h last %b",
            head_result.kind, head_result.cell_x, head_result.cell_y, head_result.entity,
            head_result.last, m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[5:3],
            m_axis_tdata[21:6], m_axis_tlast));
      end
    end
  end

  // Watchdog: counts cycles in which no transaction moves on any port.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One APB write followed by a read back of the same register. Only the low
  // four bits are held; the upper write data is random and must be dropped.
  task automatic set_map_register(input logic reg_sel, input logic [3:0] value);
    logic [CFG_DATA_W-1:0] wdata;
    wdata = $urandom;
    wdata[3:0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == REG_MAP_WIDTH) width_reg = value;
    else height_reg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[3:0] !== value)
      note_mismatch($sformatf("register %0d read back %h, expected %h", reg_sel,
                              prdata[3:0], value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Holds until every queued request is taken and every result has come back.
  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int size_w [PHASE_COUNT];
    int size_h [PHASE_COUNT];
    size_w = '{8, 1, 0, 15, 3, 8, 5, 2};
    size_h = '{8, 1, 15, 0, 7, 1, 8, 6};
    for (int i = 0; i < GRID_W*GRID_H; i++) grid_shadow[i] = '0;
    width_reg  = 4'd8;
    height_reg = 4'd8;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests at the reset map size of 8 by 8.
    push_req(ACT_SCAN, 0, 0, 8, 8, 0);            // empty grid, done only
    push_req(ACT_FILL, 0, 0, 63, 63, 16'hFFFF);   // whole grid, size clipped
    push_req(ACT_SCAN, -64, -64, 63, 63, 0);      // corner pull makes size negative
    push_req(ACT_SCAN, -3, -3, 63, 63, 0);        // full scan, 49 cells
    push_req(ACT_FILL, 2, 2, 0, 0, 0);            // clear one cell
    push_req(ACT_FILL, 7, 7, 0, 0, 16'h1234);     // bottom-right cell only
    push_req(ACT_FILL, 63, 0, 0, 0, 16'h1111);    // corner past the map
    push_req(ACT_FILL, 8, 0, 0, 0, 16'h2222);     // corner just past the last column
    push_req(ACT_FILL, 0, 63, 0, 0, 16'h3333);    // corner past the last row
    push_req(ACT_FILL, 0, 0, -64, 3, 16'h4444);   // negative width
    push_req(ACT_FILL, 0, 0, 3, -64, 16'h5555);   // negative height
    push_req(ACT_FILL, -1, -1, 3, 3, 16'h8001);   // negative corner, clipped
    push_req(ACT_SCAN, 0, 0, 1, 1, 0);            // one cell
    push_req(ACT_SCAN, 4, 4, 0, 0, 0);            // zero size, scans nothing
    push_req(ACT_SCAN, 63, 63, 63, 63, 0);        // corner past the map
    push_req(ACT_FILL, 1, 3, 5, 2, 16'h5A5A);
    push_req(ACT_SCAN, 0, 0, 63, 63, 0);
    push_req(ACT_SCAN, 0, 0, 63, -1, 0);          // height of minus one
    push_req(ACT_FILL, -64, 0, 63, 63, 16'h00FF); // width pulled to minus one
    push_req(ACT_FILL, 0, 0, 63, 63, 0);          // clear everything
    push_req(ACT_SCAN, 0, 0, 63, 63, 0);
    push_req(ACT_FILL, 0, 0, 7, 7, 16'hA5C3);
    wait_until_drained();

    // Random requests over a range of map sizes, including zero and values
    // above the grid. The first size runs with neither side stalling.
    for (int p = 0; p < PHASE_COUNT + 1; p++) begin
      repeat (12) @(posedge clk);
      if (p < PHASE_COUNT) begin
        set_map_register(REG_MAP_WIDTH, 4'(size_w[p]));
        set_map_register(REG_MAP_HEIGHT, 4'(size_h[p]));
      end else begin
        set_map_register(REG_MAP_WIDTH, 4'($urandom_range(15, 0)));
        set_map_register(REG_MAP_HEIGHT, 4'($urandom_range(15, 0)));
      end
      size_count++;
      no_stall = (p == 0);
      for (int i = 0; i < ITEMS_PER_SIZE - 6 * (p == PHASE_COUNT); i++) push_random_req();
      wait_until_drained();
    end
    no_stall = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      note_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));

    $display("Covered %0d fills, %0d scans and %0d rejected rectangles over %0d map sizes;",
             fill_count, scan_count, reject_count, size_count + 1);
    $display("%0d occupied cells reported, %0d mismatches.", found_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/grfs_pkg.sv
design/grfs_ram.sv
design/grfs_ctrl.sv
design/grfs_dp.sv
design/grid_rect_fill_scan_unit.sv
design/grfs_checker.sv
dv/grid_rect_fill_scan_unit_tb.sv
